[hw/rtl/alsf_pkg.sv]
// ----------------------------------------------------------------------------
// alsf_pkg
// Shared types, constants and the determinant micro-program for the affine
// least-squares fit core.
// ----------------------------------------------------------------------------
package alsf_pkg;

  // Default capacity of one point set
  localparam int MaxPointsDef = 1024;

  // Field and datapath widths
  localparam int PT_W    = 24;   // Q16.8 point coordinate
  localparam int PROD_W  = 2 * PT_W;
  localparam int ENT_W   = 64;   // normal-matrix entry, sign-extended
  localparam int WIDE_W  = 256;  // exact determinant arithmetic
  localparam int COEF_W  = 64;   // Q32.32 coefficient
  localparam int TOT_W   = 11;   // point_total field
  localparam int BIT_W   = $clog2(ENT_W);
  localparam int STEP_W  = 4;
  localparam int N_STEPS = 9;    // products in one 3x3 determinant
  localparam int N_COEF  = 6;
  localparam int MinPoints = 3;

  // Result scaling: offset in Q16.8 units, gains in Q32.32
  localparam int OfsShift  = 24;
  localparam int GainShift = 32;

  // fit_status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FEW  = 2'd1;
  localparam logic [1:0] ST_SING = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  typedef struct packed {
    logic signed [PT_W-1:0] src_x;
    logic signed [PT_W-1:0] src_y;
    logic signed [PT_W-1:0] dst_x;
    logic signed [PT_W-1:0] dst_y;
    logic                   last_point;
  } in_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] x_offset;
    logic signed [COEF_W-1:0] x_from_src_x;
    logic signed [COEF_W-1:0] x_from_src_y;
    logic signed [COEF_W-1:0] y_offset;
    logic signed [COEF_W-1:0] y_from_src_x;
    logic signed [COEF_W-1:0] y_from_src_y;
    logic [1:0]               fit_status;
    logic [TOT_W-1:0]         point_total;
  } out_t;

  // What to do with a finished product
  typedef enum logic [2:0] {
    OP_T_SET,
    OP_T_SUB,
    OP_D_SET,
    OP_D_SUB,
    OP_D_ADD
  } mac_op_t;

  // One product of the determinant expansion
  typedef struct packed {
    logic       a_is_t;   // multiplicand is the 2x2 minor register
    logic [1:0] a_r;
    logic [1:0] a_c;
    logic [1:0] b_r;
    logic [1:0] b_c;
    mac_op_t    op;
  } uop_t;

  // Controller to datapath
  typedef struct packed {
    logic             accept;
    logic             clear;
    logic             clr_coef;
    logic             mul_load;
    logic             mul_step;
    logic             mul_last;
    logic             macc;
    logic             save_det;
    logic             div_start;
    logic             coef_wr;
    logic             out_load;
    logic [STEP_W-1:0] step;
    logic [1:0]       col;     // 0 = plain matrix, 1..3 = column replaced
    logic             axis;    // 0 = destination x, 1 = destination y
    logic [1:0]       status;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic few_pts;
    logic det_zero;
    logic ovf;
    logic div_done;
    logic out_busy;
  } sts_t;

  // Cofactor expansion along row 0:
  //   det = m00(m11m22 - m12m21) - m01(m10m22 - m12m20) + m02(m10m21 - m11m20)
  function automatic uop_t uop_f(input logic [STEP_W-1:0] step);
    uop_t u;
    u = '{a_is_t: 1'b0, a_r: 2'd0, a_c: 2'd0, b_r: 2'd0, b_c: 2'd0, op: OP_T_SET};
    unique case (step)
      4'd0: u = '{1'b0, 2'd1, 2'd1, 2'd2, 2'd2, OP_T_SET};
      4'd1: u = '{1'b0, 2'd1, 2'd2, 2'd2, 2'd1, OP_T_SUB};
      4'd2: u = '{1'b1, 2'd0, 2'd0, 2'd0, 2'd0, OP_D_SET};
      4'd3: u = '{1'b0, 2'd1, 2'd0, 2'd2, 2'd2, OP_T_SET};
      4'd4: u = '{1'b0, 2'd1, 2'd2, 2'd2, 2'd0, OP_T_SUB};
      4'd5: u = '{1'b1, 2'd0, 2'd0, 2'd0, 2'd1, OP_D_SUB};
      4'd6: u = '{1'b0, 2'd1, 2'd0, 2'd2, 2'd1, OP_T_SET};
      4'd7: u = '{1'b0, 2'd1, 2'd1, 2'd2, 2'd0, OP_T_SUB};
      4'd8: u = '{1'b1, 2'd0, 2'd0, 2'd0, 2'd2, OP_D_ADD};
      default: u = '{1'b0, 2'd0, 2'd0, 2'd0, 2'd0, OP_T_SET};
    endcase
    return u;
  endfunction

endpackage

[hw/rtl/alsf_ctrl.sv]
// ----------------------------------------------------------------------------
// alsf_ctrl
// Sequencer: accumulation, up to seven determinants, six divisions, result.
// ----------------------------------------------------------------------------
module alsf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_stall,
  input  alsf_pkg::sts_t   sts,
  output alsf_pkg::cmd_t   cmd
);

  typedef enum logic [7:0] {
    S_ACC   = 8'b0000_0001,
    S_DRAIN = 8'b0000_0010,
    S_LOAD  = 8'b0000_0100,
    S_RUN   = 8'b0000_1000,
    S_MACC  = 8'b0001_0000,
    S_DET   = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_RES   = 8'b1000_0000
  } state_t;

  state_t                           state_r, state_nxt;
  logic [alsf_pkg::STEP_W-1:0]      step_r, step_nxt;
  logic [1:0]                       col_r, col_nxt;
  logic                             axis_r, axis_nxt;
  logic [alsf_pkg::BIT_W-1:0]       bit_r, bit_nxt;
  logic [1:0]                       stat_r, stat_nxt;
  logic                             bit_end;

  assign bit_end  = (bit_r == alsf_pkg::BIT_W'(alsf_pkg::ENT_W - 1));
  assign in_stall = (state_r != S_ACC);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    col_nxt   = col_r;
    axis_nxt  = axis_r;
    bit_nxt   = bit_r;
    stat_nxt  = stat_r;
    cmd       = '0;
    cmd.step   = step_r;
    cmd.col    = col_r;
    cmd.axis   = axis_r;
    cmd.status = stat_r;
    unique case (state_r)
      S_ACC: begin
        cmd.accept = in_valid;
        if (in_valid && in_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        cmd.clr_coef = 1'b1;
        step_nxt = '0;
        col_nxt  = 2'd0;
        axis_nxt = 1'b0;
        if (sts.few_pts) begin
          stat_nxt  = alsf_pkg::ST_FEW;
          state_nxt = S_RES;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.mul_load = 1'b1;
        bit_nxt   = '0;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        cmd.mul_step = 1'b1;
        cmd.mul_last = bit_end;
        bit_nxt = bit_r + 1'b1;
        if (bit_end) state_nxt = S_MACC;
      end
      S_MACC: begin
        cmd.macc = 1'b1;
        if (step_r == alsf_pkg::STEP_W'(alsf_pkg::N_STEPS - 1)) begin
          state_nxt = S_DET;
        end else begin
          step_nxt  = step_r + 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_DET: begin
        step_nxt = '0;
        if (col_r == 2'd0) begin
          if (sts.det_zero) begin
            stat_nxt  = alsf_pkg::ST_SING;
            state_nxt = S_RES;
          end else begin
            cmd.save_det = 1'b1;
            col_nxt   = 2'd1;
            state_nxt = S_LOAD;
          end
        end else begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.coef_wr = 1'b1;
          if (col_r == 2'd3) begin
            if (axis_r) begin
              stat_nxt  = sts.ovf ? alsf_pkg::ST_OVF : alsf_pkg::ST_OK;
              state_nxt = S_RES;
            end else begin
              axis_nxt  = 1'b1;
              col_nxt   = 2'd1;
              state_nxt = S_LOAD;
            end
          end else begin
            col_nxt   = col_r + 1'b1;
            state_nxt = S_LOAD;
          end
        end
      end
      S_RES: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.clear    = 1'b1;
          state_nxt    = S_ACC;
        end
      end
      default: state_nxt = S_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
      step_r  <= '0;
      col_r   <= 2'd0;
      axis_r  <= 1'b0;
      bit_r   <= '0;
      stat_r  <= alsf_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      col_r   <= col_nxt;
      axis_r  <= axis_nxt;
      bit_r   <= bit_nxt;
      stat_r  <= stat_nxt;
    end
  end

endmodule

[hw/rtl/alsf_div.sv]
// ----------------------------------------------------------------------------
// alsf_div
// Radix-2 restoring divider: round(num / den) half away from zero,
// saturated to a signed 64-bit coefficient.
// ----------------------------------------------------------------------------
module alsf_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [alsf_pkg::WIDE_W-1:0]  num,
  input  logic signed [alsf_pkg::WIDE_W-1:0]  den,
  output logic                                done,
  output logic signed [alsf_pkg::COEF_W-1:0]  quo
);

  localparam int W   = alsf_pkg::WIDE_W;
  localparam int CW  = alsf_pkg::COEF_W;
  localparam int CNT_W = $clog2(W);

  typedef enum logic [3:0] {
    DV_IDLE = 4'b0001,
    DV_PREP = 4'b0010,
    DV_RUN  = 4'b0100,
    DV_FIN  = 4'b1000
  } dstate_t;

  dstate_t            state_r, state_nxt;
  logic [W-1:0]       n_r, d_r, dvd_r;
  logic [W:0]         dvs_r, rem_r;
  logic               neg_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               done_r;
  logic signed [CW-1:0] quo_r;

  logic [W+1:0]       rem_sh, rem_diff;
  logic               ge;
  logic               big;
  logic [CW-1:0]      mag;

  // One quotient bit per cycle
  assign rem_sh   = {rem_r, dvd_r[W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_r};
  assign ge       = (rem_sh >= {1'b0, dvs_r});
  assign big      = |dvd_r[W-1:CW-1];
  assign mag      = dvd_r[CW-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DV_IDLE: if (start) state_nxt = DV_PREP;
      DV_PREP: state_nxt = DV_RUN;
      DV_RUN:  if (cnt_r == '0) state_nxt = DV_FIN;
      DV_FIN:  state_nxt = DV_IDLE;
      default: state_nxt = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == DV_FIN);
    end
  end

  // Operand and iteration registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      DV_IDLE: begin
        if (start) begin
          n_r   <= num[W-1] ? W'(-num) : W'(num);
          d_r   <= den[W-1] ? W'(-den) : W'(den);
          neg_r <= num[W-1] ^ den[W-1];
        end
      end
      DV_PREP: begin
        // (2|n| + |d|) / (2|d|) rounds half away from zero
        dvd_r <= {n_r[W-2:0], 1'b0} + d_r;
        dvs_r <= {d_r, 1'b0};
        rem_r <= '0;
        cnt_r <= CNT_W'(W - 1);
      end
      DV_RUN: begin
        rem_r <= ge ? rem_diff[W:0] : rem_sh[W:0];
        dvd_r <= {dvd_r[W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
      end
      DV_FIN: begin
        if (big) quo_r <= neg_r ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        else     quo_r <= neg_r ? CW'(-mag) : mag;
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[hw/rtl/alsf_dp.sv]
// ----------------------------------------------------------------------------
// alsf_dp
// Datapath: sum accumulation, bit-serial 256-bit multiply-accumulate for the
// determinants, divider and the result register.
// ----------------------------------------------------------------------------
module alsf_dp #(
  parameter int MAX_POINTS = alsf_pkg::MaxPointsDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  alsf_pkg::in_t   in_data,
  input  alsf_pkg::cmd_t  cmd,
  input  logic            out_stall,
  output alsf_pkg::sts_t  sts,
  output logic            out_valid,
  output alsf_pkg::out_t  out_data
);

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int LIN_W  = alsf_pkg::PT_W + $clog2(MAX_POINTS);
  localparam int SQ_W   = alsf_pkg::PROD_W + $clog2(MAX_POINTS);
  localparam int PT_W   = alsf_pkg::PT_W;
  localparam int PROD_W = alsf_pkg::PROD_W;
  localparam int ENT_W  = alsf_pkg::ENT_W;
  localparam int W      = alsf_pkg::WIDE_W;
  localparam int CW     = alsf_pkg::COEF_W;

  // Accumulation state
  logic [CNT_W-1:0]        cnt_r;
  logic                    ovf_r;
  logic                    keep;
  logic                    s_keep_r;
  logic signed [PT_W-1:0]  s_lin_r [4];
  logic signed [PROD_W-1:0] s_sq_r [3];
  logic signed [PROD_W-1:0] s_cr_r [4];
  logic signed [LIN_W-1:0] lin_r [4];
  logic signed [SQ_W-1:0]  sq_r [3];
  logic signed [SQ_W-1:0]  cr_r [4];

  // Solve state
  logic signed [ENT_W-1:0] mat [3][3];
  logic signed [ENT_W-1:0] rhs [2][3];
  logic signed [ENT_W-1:0] ent_a, ent_b;
  alsf_pkg::uop_t          u;
  logic signed [W-1:0]     ma_r, p_r, t_r, d_r, det_r;
  logic [ENT_W-1:0]        mb_r;
  logic signed [W-1:0]     div_num;
  logic                    div_done;
  logic signed [CW-1:0]    div_quo;
  logic [2:0]              cidx;
  logic signed [CW-1:0]    coef_r [alsf_pkg::N_COEF];
  logic                    out_valid_r;
  alsf_pkg::out_t          out_r;

  assign keep = (cnt_r < CNT_W'(MAX_POINTS));

  // Count, overflow and running sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      s_keep_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        lin_r[i] <= '0;
        cr_r[i]  <= '0;
      end
      for (int i = 0; i < 3; i++) sq_r[i] <= '0;
    end else begin
      s_keep_r <= cmd.accept && keep;
      if (cmd.clear) begin
        cnt_r <= '0;
        ovf_r <= 1'b0;
        for (int i = 0; i < 4; i++) begin
          lin_r[i] <= '0;
          cr_r[i]  <= '0;
        end
        for (int i = 0; i < 3; i++) sq_r[i] <= '0;
      end else begin
        if (cmd.accept) begin
          if (keep) cnt_r <= cnt_r + 1'b1;
          else      ovf_r <= 1'b1;
        end
        if (s_keep_r) begin
          for (int i = 0; i < 4; i++) begin
            lin_r[i] <= lin_r[i] + LIN_W'(s_lin_r[i]);
            cr_r[i]  <= cr_r[i] + SQ_W'(s_cr_r[i]);
          end
          for (int i = 0; i < 3; i++) sq_r[i] <= sq_r[i] + SQ_W'(s_sq_r[i]);
        end
      end
    end
  end

  // Product stage of the accepted request
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s_lin_r[0] <= in_data.src_x;
      s_lin_r[1] <= in_data.src_y;
      s_lin_r[2] <= in_data.dst_x;
      s_lin_r[3] <= in_data.dst_y;
      s_sq_r[0]  <= PROD_W'(in_data.src_x) * PROD_W'(in_data.src_x);
      s_sq_r[1]  <= PROD_W'(in_data.src_y) * PROD_W'(in_data.src_y);
      s_sq_r[2]  <= PROD_W'(in_data.src_x) * PROD_W'(in_data.src_y);
      s_cr_r[0]  <= PROD_W'(in_data.dst_x) * PROD_W'(in_data.src_x);
      s_cr_r[1]  <= PROD_W'(in_data.dst_y) * PROD_W'(in_data.src_x);
      s_cr_r[2]  <= PROD_W'(in_data.dst_x) * PROD_W'(in_data.src_y);
      s_cr_r[3]  <= PROD_W'(in_data.dst_y) * PROD_W'(in_data.src_y);
    end
  end

  // Normal matrix and right-hand sides
  always_comb begin
    mat[0][0] = ENT_W'(cnt_r);
    mat[0][1] = ENT_W'(lin_r[0]);
    mat[1][0] = ENT_W'(lin_r[0]);
    mat[0][2] = ENT_W'(lin_r[1]);
    mat[2][0] = ENT_W'(lin_r[1]);
    mat[1][1] = ENT_W'(sq_r[0]);
    mat[2][2] = ENT_W'(sq_r[1]);
    mat[1][2] = ENT_W'(sq_r[2]);
    mat[2][1] = ENT_W'(sq_r[2]);
    rhs[0][0] = ENT_W'(lin_r[2]);
    rhs[0][1] = ENT_W'(cr_r[0]);
    rhs[0][2] = ENT_W'(cr_r[2]);
    rhs[1][0] = ENT_W'(lin_r[3]);
    rhs[1][1] = ENT_W'(cr_r[1]);
    rhs[1][2] = ENT_W'(cr_r[3]);
  end

  // Operand selection with Cramer column replacement
  assign u = alsf_pkg::uop_f(cmd.step);

  always_comb begin
    if (cmd.col != 2'd0 && u.a_c == cmd.col - 2'd1) ent_a = rhs[cmd.axis][u.a_r];
    else                                            ent_a = mat[u.a_r][u.a_c];
    if (cmd.col != 2'd0 && u.b_c == cmd.col - 2'd1) ent_b = rhs[cmd.axis][u.b_r];
    else                                            ent_b = mat[u.b_r][u.b_c];
  end

  // Bit-serial multiply and accumulate into minor / determinant
  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      ma_r <= u.a_is_t ? t_r : W'(ent_a);
      mb_r <= ent_b;
      p_r  <= '0;
    end else if (cmd.mul_step) begin
      if (mb_r[0]) p_r <= cmd.mul_last ? p_r - ma_r : p_r + ma_r;
      ma_r <= ma_r <<< 1;
      mb_r <= mb_r >> 1;
    end
    if (cmd.macc) begin
      unique case (u.op)
        alsf_pkg::OP_T_SET: t_r <= p_r;
        alsf_pkg::OP_T_SUB: t_r <= t_r - p_r;
        alsf_pkg::OP_D_SET: d_r <= p_r;
        alsf_pkg::OP_D_SUB: d_r <= d_r - p_r;
        alsf_pkg::OP_D_ADD: d_r <= d_r + p_r;
        default: ;
      endcase
    end
    if (cmd.save_det) det_r <= d_r;
  end

  // Offset is solved in Q16.8 units, gains in Q32.32
  assign div_num = (cmd.col == 2'd1) ? (d_r <<< alsf_pkg::OfsShift)
                                     : (d_r <<< alsf_pkg::GainShift);

  alsf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (det_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Coefficient store
  assign cidx = (cmd.axis ? 3'd3 : 3'd0) + {1'b0, cmd.col} - 3'd1;

  always_ff @(posedge clk) begin
    if (cmd.clr_coef) begin
      for (int i = 0; i < alsf_pkg::N_COEF; i++) coef_r[i] <= '0;
    end else if (cmd.coef_wr) begin
      coef_r[cidx] <= div_quo;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.x_offset     <= coef_r[0];
      out_r.x_from_src_x <= coef_r[1];
      out_r.x_from_src_y <= coef_r[2];
      out_r.y_offset     <= coef_r[3];
      out_r.y_from_src_x <= coef_r[4];
      out_r.y_from_src_y <= coef_r[5];
      out_r.fit_status   <= cmd.status;
      out_r.point_total  <= alsf_pkg::TOT_W'(cnt_r);
    end
  end

  assign sts.few_pts  = (cnt_r < CNT_W'(alsf_pkg::MinPoints));
  assign sts.det_zero = (d_r == '0);
  assign sts.ovf      = ovf_r;
  assign sts.div_done = div_done;
  assign sts.out_busy = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[hw/rtl/affine_least_squares_fit_core.sv]
// ----------------------------------------------------------------------------
// affine_least_squares_fit_core
// Streams matched point pairs and solves the 3x3 affine normal equations.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_data): one point pair per request,
// one request per cycle while the set is being accumulated. A request with
// last_point set closes the set; in_stall then stays high while the set is
// solved and until the result has a place in the output register.
// Output channel (out_valid / out_stall / out_data): one result per set, six
// Q32.32 coefficients, fit_status and point_total. The result sits in a
// register, so a new set is accepted while an earlier result is held back
// by out_stall.
// The solve after the last pair is paced by the bit-serial 256-bit
// multiply-accumulate (9 products per determinant, 7 determinants) and
// the radix-2 divider (one division for each of the 6 coefficients).
// Fewer than 3 pairs skip the solve and go from the drain state straight
// to the result, a singular system finishes after the first determinant.
// Pairs beyond MAX_POINTS are dropped and reported as overflow unless the system is singular.
// Reset (rst_n low, synchronous) clears all sums, counts and the output valid.
// ----------------------------------------------------------------------------
module affine_least_squares_fit_core #(
  parameter int MAX_POINTS = alsf_pkg::MaxPointsDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  alsf_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output alsf_pkg::out_t  out_data
);

  alsf_pkg::cmd_t cmd;
  alsf_pkg::sts_t sts;

  alsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_point),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  alsf_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Closing a set always stops the input for the solve
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last_point |=> in_stall)
    else $error("input not stalled after last point");

  // Too few points or singular system gives zero coefficients
  a_zero_coef: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.fit_status == alsf_pkg::ST_FEW ||
                  out_data.fit_status == alsf_pkg::ST_SING)
    |-> out_data.x_offset == '0 && out_data.x_from_src_x == '0 &&
        out_data.x_from_src_y == '0 && out_data.y_offset == '0 &&
        out_data.y_from_src_x == '0 && out_data.y_from_src_y == '0)
    else $error("nonzero coefficients on failed fit");

  // A not-enough result really has fewer than three points
  a_few_count: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && out_data.fit_status == alsf_pkg::ST_FEW
    |-> out_data.point_total < alsf_pkg::TOT_W'(alsf_pkg::MinPoints))
    else $error("not-enough status with three or more points");

  // A new result only appears while the input is held
  a_res_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result loaded while accumulating");

endmodule
